/* src/quat_to_rotation_matrix_macros.svh */
// Assertion macros for the quaternion to rotation matrix block
`ifndef QUAT_TO_ROTATION_MATRIX_MACROS_SVH
`define QUAT_TO_ROTATION_MATRIX_MACROS_SVH

// Checked on every rising clock edge outside reset
`define QTR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("qtr assertion failed");

// A signal holds across a cycle in which cond is high
`define QTR_ASSERT_HOLD(lbl, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) cond |=> $stable(sig)) \
		else $error("qtr hold assertion failed");

`endif

/* src/qtr_pkg.sv */
// Types, widths and helpers for the quaternion to rotation matrix block
package qtr_pkg;

	localparam int DW = 16;
	localparam int FW = DW - 2;
	localparam int TW = 10;
	localparam int PW = 2 * DW;
	localparam int QW = 2 * DW + 1;
	localparam int RW = QW + 1;
	localparam int NW = 2 * DW + 2;
	localparam int NENT = 9;

	localparam logic signed [DW-1:0] ONE = DW'(1) <<< FW;
	localparam logic [TW-1:0] THRESH_RST = TW'(1);

	typedef logic signed [DW-1:0] fix_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [NW-1:0] num_t;
	typedef logic [QW-1:0] mag_t;
	typedef logic [DW-1:0] quo_t;

	typedef struct packed {
		fix_t quat_w;
		fix_t quat_x;
		fix_t quat_y;
		fix_t quat_z;
	} quat_t;

	typedef struct packed {
		fix_t m00;
		fix_t m01;
		fix_t m02;
		fix_t m10;
		fix_t m11;
		fix_t m12;
		fix_t m20;
		fix_t m21;
		fix_t m22;
		logic degenerate;
	} mat_t;

	typedef struct packed {
		logic vld;
		logic degen;
	} div_tag_t;

	function automatic num_t sx(prod_t v);
		return {{(NW - PW){v[PW-1]}}, v};
	endfunction

endpackage

/* src/qtr_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, nine lanes sharing one divisor
module qtr_div_pipe import qtr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  div_tag_t            tag_in,
	input  mag_t                quad_in,
	input  mag_t [NENT-1:0]     mag_in,
	input  logic [NENT-1:0]     neg_in,
	output div_tag_t            tag_out,
	output quo_t [NENT-1:0]     quo_out,
	output logic [NENT-1:0]     neg_out
);

	mag_t             rem_s  [DW][NENT];
	quo_t             quo_s  [DW][NENT];
	mag_t             quad_s [DW];
	logic [NENT-1:0]  neg_s  [DW];
	div_tag_t         tag_s  [DW];

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [RW-1:0]   r2_p  [NENT];
		quo_t            quo_p [NENT];
		mag_t            rem_d [NENT];
		quo_t            quo_d [NENT];
		mag_t            quad_p;
		logic [NENT-1:0] neg_p;
		div_tag_t        tag_p;

		if (k == 0) begin : g_head
			always_comb begin
				quad_p = quad_in;
				neg_p = neg_in;
				tag_p = tag_in;
				for (int i = 0; i < NENT; i++) begin
					r2_p[i] = {1'b0, mag_in[i]};
					quo_p[i] = '0;
				end
			end
		end else begin : g_tail
			always_comb begin
				quad_p = quad_s[k-1];
				neg_p = neg_s[k-1];
				tag_p = tag_s[k-1];
				for (int i = 0; i < NENT; i++) begin
					r2_p[i] = {rem_s[k-1][i], 1'b0};
					quo_p[i] = {quo_s[k-1][i][DW-2:0], 1'b0};
				end
			end
		end

		always_comb begin
			logic qb;
			for (int i = 0; i < NENT; i++) begin
				qb = (r2_p[i] >= {1'b0, quad_p});
				rem_d[i] = qb ? QW'(r2_p[i] - {1'b0, quad_p}) : QW'(r2_p[i]);
				quo_d[i] = {quo_p[i][DW-1:1], qb};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (en) begin
				tag_s[k] <= tag_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quad_s[k] <= quad_p;
				neg_s[k] <= neg_p;
				for (int i = 0; i < NENT; i++) begin
					rem_s[k][i] <= rem_d[i];
					quo_s[k][i] <= quo_d[i];
				end
			end
		end
	end

	assign tag_out = tag_s[DW-1];
	assign neg_out = neg_s[DW-1];
	always_comb begin
		for (int i = 0; i < NENT; i++) begin
			quo_out[i] = quo_s[DW-1][i];
		end
	end

endmodule

/* src/quat_to_rotation_matrix.sv */
// Top level: quaternion in, normalized 3x3 rotation matrix out
//
//  channel | signals                         | payload
//  --------+---------------------------------+-----------------------------
//  input   | quat_valid, quat_ready, quat    | quat_t (w, x, y, z, Q2.14)
//  output  | mat_valid, mat_ready, mat       | mat_t (m00..m22, degenerate)
//  config  | cfg_valid, cfg_ready, cfg_data  | flush threshold, 10 bits
//
// One transfer per cycle while the output is not stalled; a result passes through
// registered products, sums, one stage per quotient bit of the shared-divisor
// divider, then rounding.
// Reset clears valid bits and sets the flush threshold to 1.
// A stall at the output freezes the whole pipe; nothing is lost or repeated.
`include "quat_to_rotation_matrix_macros.svh"

module quat_to_rotation_matrix import qtr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           quat_valid,
	output logic           quat_ready,
	input  quat_t          quat,
	output logic           mat_valid,
	input  logic           mat_ready,
	output mat_t           mat,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [TW-1:0]  cfg_data
);

	localparam logic signed [DW+1:0] SAT_HI = (DW+2)'(2 ** (DW - 1) - 1);
	localparam logic signed [DW+1:0] SAT_LO = ~SAT_HI;

	logic [TW-1:0] flush_q;
	logic          en;

	prod_t ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, xw_s1, yz_s1, yw_s1, zw_s1;
	logic  vld_s1;

	num_t            num [NENT];
	num_t            quad_n;
	mag_t [NENT-1:0] mag_d;
	logic [NENT-1:0] neg_d;

	mag_t [NENT-1:0] mag_s2;
	logic [NENT-1:0] neg_s2;
	mag_t            quad_s2;
	div_tag_t        tag_s2;

	div_tag_t        tag_dv;
	quo_t [NENT-1:0] quo_dv;
	logic [NENT-1:0] neg_dv;

	fix_t ent [NENT];
	mat_t mat_q;
	logic mat_valid_q;

	assign cfg_ready = 1'b1;
	assign en = !mat_valid_q || mat_ready;
	assign quat_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= THRESH_RST;
		end else if (cfg_valid) begin
			flush_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			tag_s2 <= '0;
			mat_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= quat_valid;
			tag_s2.vld <= vld_s1;
			tag_s2.degen <= (quad_n == '0);
			mat_valid_q <= tag_dv.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= quat.quat_w * quat.quat_w;
			xx_s1 <= quat.quat_x * quat.quat_x;
			yy_s1 <= quat.quat_y * quat.quat_y;
			zz_s1 <= quat.quat_z * quat.quat_z;
			xy_s1 <= quat.quat_x * quat.quat_y;
			xz_s1 <= quat.quat_x * quat.quat_z;
			xw_s1 <= quat.quat_x * quat.quat_w;
			yz_s1 <= quat.quat_y * quat.quat_z;
			yw_s1 <= quat.quat_y * quat.quat_w;
			zw_s1 <= quat.quat_z * quat.quat_w;
		end
	end

	always_comb begin
		quad_n = sx(ww_s1) + sx(xx_s1) + sx(yy_s1) + sx(zz_s1);
		num[0] = sx(ww_s1) + sx(xx_s1) - sx(yy_s1) - sx(zz_s1);
		num[1] = (sx(xy_s1) - sx(zw_s1)) <<< 1;
		num[2] = (sx(xz_s1) + sx(yw_s1)) <<< 1;
		num[3] = (sx(xy_s1) + sx(zw_s1)) <<< 1;
		num[4] = sx(ww_s1) - sx(xx_s1) + sx(yy_s1) - sx(zz_s1);
		num[5] = (sx(yz_s1) - sx(xw_s1)) <<< 1;
		num[6] = (sx(xz_s1) - sx(yw_s1)) <<< 1;
		num[7] = (sx(yz_s1) + sx(xw_s1)) <<< 1;
		num[8] = sx(ww_s1) - sx(xx_s1) - sx(yy_s1) + sx(zz_s1);
		for (int i = 0; i < NENT; i++) begin
			neg_d[i] = num[i][NW-1];
			mag_d[i] = neg_d[i] ? QW'(-num[i]) : QW'(num[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s2 <= quad_n[QW-1:0];
			mag_s2 <= mag_d;
			neg_s2 <= neg_d;
		end
	end

	qtr_div_pipe u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_s2),
		.quad_in (quad_s2),
		.mag_in  (mag_s2),
		.neg_in  (neg_s2),
		.tag_out (tag_dv),
		.quo_out (quo_dv),
		.neg_out (neg_dv)
	);

	always_comb begin
		logic [DW:0]             qr;
		logic signed [DW+1:0]    sv;
		logic [DW:0]             am;
		for (int i = 0; i < NENT; i++) begin
			qr = ({1'b0, quo_dv[i]} + (DW+1)'(1)) >> 1;
			sv = neg_dv[i] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
			if (sv > SAT_HI) begin
				sv = SAT_HI;
			end else if (sv < SAT_LO) begin
				sv = SAT_LO;
			end
			am = sv[DW+1] ? (DW+1)'(-sv) : (DW+1)'(sv);
			if (am < (DW+1)'(flush_q)) begin
				ent[i] = '0;
			end else begin
				ent[i] = sv[DW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tag_dv.degen) begin
				mat_q <= '{ONE, '0, '0, '0, ONE, '0, '0, '0, ONE, 1'b1};
			end else begin
				mat_q <= '{ent[0], ent[1], ent[2], ent[3], ent[4], ent[5],
					ent[6], ent[7], ent[8], 1'b0};
			end
		end
	end

	assign mat_valid = mat_valid_q;
	assign mat = mat_q;

	`QTR_ASSERT(a_cfg_write, cfg_valid |=> flush_q == $past(cfg_data))
	`QTR_ASSERT_HOLD(a_stall_s2, !en, tag_s2)
	`QTR_ASSERT_HOLD(a_stall_div, !en && tag_dv.vld, quo_dv)
	`QTR_ASSERT(a_degen_id, mat_valid && mat.degenerate |-> mat.m00 == ONE && mat.m01 == '0)
	`QTR_ASSERT(a_diag_range, mat_valid |-> mat.m11 <= ONE && mat.m11 >= -ONE)

endmodule
